### hw/rtl/smfe_pkg.sv
`timescale 1ns / 1ps

package smfe_pkg;

  // Transform geometry
  localparam int FFT_SIZE = 1024;
  localparam int LOG2N    = 10;
  localparam int NUM_BINS = 513;
  localparam int ADDR_W   = LOG2N;
  localparam int BIN_W    = 10;
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 32;
  localparam int MAG_W    = 28;
  localparam int HOP_W    = 11;
  localparam int FRAME_W  = 16;
  localparam int STAGE_W  = 4;
  localparam int BF_W     = LOG2N - 1;

  localparam logic [HOP_W-1:0]   HOP_RESET = 11'd256;
  localparam logic [HOP_W-1:0]   SEEN_FULL = HOP_W'(FFT_SIZE);
  localparam logic [BIN_W-1:0]   BIN_LAST  = BIN_W'(NUM_BINS - 1);
  localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};

  // Command codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_FRAME  = 3'd1,
    ST_LOST   = 3'd2,
    ST_BIN    = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  // Frame launch request from the command side
  typedef struct packed {
    logic              go;
    logic [ADDR_W-1:0] base;
  } frame_req_t;

  // Write port into the magnitude store
  typedef struct packed {
    logic             we;
    logic [BIN_W-1:0] addr;
    logic [MAG_W-1:0] data;
  } mag_wr_t;

  // First-quadrant cos/sin in Q30, one entry per 1/FFT_SIZE turn
  typedef logic [30:0] trig_tab_t [0:255];

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Taylor term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
  localparam logic [63:0] SIN_DIV [1:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                            64'd156, 64'd210, 64'd272, 64'd342};
  localparam logic [63:0] COS_DIV [1:9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                            64'd132, 64'd182, 64'd240, 64'd306};

  function automatic trig_tab_t build_trig(input logic want_cos);
    trig_tab_t   tab;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] term;
    longint      acc;
    for (int m = 0; m < 256; m++) begin
      th = ((64'(m) * (PI_Q62 >> 21)) / FFT_SIZE + 64'd512) >> 10;
      t2 = (th * th + (64'd1 << 29)) >> 30;
      if (want_cos) begin
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 1; n <= 9; n++) begin
          term = ((term * t2 + (64'd1 << 29)) >> 30) / COS_DIV[n];
          acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
      end else begin
        term = th;
        acc  = longint'(th);
        for (int n = 1; n <= 9; n++) begin
          term = ((term * t2 + (64'd1 << 29)) >> 30) / SIN_DIV[n];
          acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
      end
      tab[m] = acc[30:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b1);
  localparam trig_tab_t SIN_TAB = build_trig(1'b0);

endpackage

### hw/rtl/stft_magnitude_frame_engine_core.sv
`timescale 1ns / 1ps
// A push that starts no frame gives its item in the cycle after accept; a read passes
// through S_READ, where the stored magnitude is loaded. A push that completes a frame holds
// busy while the window, butterflies and magnitudes run on the one shared multiplier, the
// work RAM and the bit-serial square root. No new item is accepted while busy.
// Results show for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears counters and out_valid and sets hop to 256.

module stft_magnitude_frame_engine_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic signed [smfe_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [smfe_pkg::MAG_W-1:0]         out_magnitude,
  output logic [smfe_pkg::BIN_W-1:0]         out_bin_index,
  output logic [smfe_pkg::FRAME_W-1:0]       out_frame_number,
  output logic                               out_last_bin,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smfe_pkg::HOP_W-1:0]         cfg_hop
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_FRAME} top_state_t;

  localparam int AW = smfe_pkg::ADDR_W;
  localparam int HW = smfe_pkg::HOP_W;

  top_state_t                        state_r;
  logic [HW-1:0]                     hop_r;
  logic [HW-1:0]                     seen_r;
  logic [HW-1:0]                     hop_cnt_r;
  logic [smfe_pkg::BIN_W-1:0]        rd_ptr_r;
  logic                              pending_r;
  logic [smfe_pkg::FRAME_W-1:0]      frame_cnt_r;
  logic [AW-1:0]                     ring_pos_r;
  logic                              out_valid_r;
  smfe_pkg::status_t                 out_status_r;
  logic [smfe_pkg::MAG_W-1:0]        out_mag_r;
  logic [smfe_pkg::BIN_W-1:0]        out_idx_r;
  logic [smfe_pkg::FRAME_W-1:0]      out_fnum_r;
  logic                              out_last_r;

  logic                              accept;
  logic                              push;
  logic [HW-1:0]                     hop_eff;
  logic                              fire;
  logic                              last;
  smfe_pkg::frame_req_t              req;
  logic                              frm_done;
  logic [AW-1:0]                     ring_raddr;
  logic signed [smfe_pkg::SAMPLE_W-1:0] ring_rdata;
  smfe_pkg::mag_wr_t                 mag_wr;
  logic [smfe_pkg::MAG_W-1:0]        mag_rdata;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign push      = (in_func == smfe_pkg::FUNC_PUSH);
  assign hop_eff   = (hop_r == '0) ? HW'(1) : hop_r;
  assign last      = (rd_ptr_r == smfe_pkg::BIN_LAST);

  // Frame fires on the first full ring, then every hop pushes
  assign fire = (seen_r != smfe_pkg::SEEN_FULL) ? ((seen_r + HW'(1)) == smfe_pkg::SEEN_FULL)
                                               : ((hop_cnt_r + HW'(1)) >= hop_eff);

  assign req.go   = accept && push && fire;
  assign req.base = ring_pos_r + AW'(1);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_magnitude    = out_mag_r;
  assign out_bin_index    = out_idx_r;
  assign out_frame_number = out_fnum_r;
  assign out_last_bin     = out_last_r;

  // Command sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hop_r       <= smfe_pkg::HOP_RESET;
      seen_r      <= '0;
      hop_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      pending_r   <= 1'b0;
      frame_cnt_r <= '0;
      ring_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        hop_r <= cfg_hop;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_mag_r  <= '0;
            out_idx_r  <= '0;
            out_fnum_r <= '0;
            out_last_r <= 1'b0;
            if (push) begin
              ring_pos_r <= ring_pos_r + AW'(1);
              if (seen_r != smfe_pkg::SEEN_FULL) begin
                seen_r <= seen_r + HW'(1);
              end else begin
                hop_cnt_r <= hop_cnt_r + HW'(1);
              end
              if (fire) begin
                hop_cnt_r    <= '0;
                frame_cnt_r  <= frame_cnt_r + smfe_pkg::FRAME_W'(1);
                rd_ptr_r     <= '0;
                pending_r    <= 1'b1;
                out_status_r <= pending_r ? smfe_pkg::ST_LOST : smfe_pkg::ST_FRAME;
                state_r      <= S_FRAME;
              end else begin
                out_status_r <= smfe_pkg::ST_STORED;
                out_valid_r  <= 1'b1;
              end
            end else if (pending_r) begin
              out_status_r <= smfe_pkg::ST_BIN;
              out_idx_r    <= rd_ptr_r;
              out_fnum_r   <= frame_cnt_r - smfe_pkg::FRAME_W'(1);
              out_last_r   <= last;
              rd_ptr_r     <= rd_ptr_r + smfe_pkg::BIN_W'(1);
              if (last) begin
                pending_r <= 1'b0;
              end
              state_r <= S_READ;
            end else begin
              out_status_r <= smfe_pkg::ST_EMPTY;
              out_valid_r  <= 1'b1;
            end
          end
        end
        S_READ: begin
          out_mag_r   <= mag_rdata;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_FRAME: begin
          if (frm_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  smfe_ram #(.WIDTH(smfe_pkg::SAMPLE_W), .DEPTH(smfe_pkg::FFT_SIZE)) u_ring (
    .clk   (clk),
    .we    (accept && push),
    .waddr (ring_pos_r),
    .wdata (in_sample),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  smfe_ram #(.WIDTH(smfe_pkg::MAG_W), .DEPTH(smfe_pkg::NUM_BINS)) u_mag (
    .clk   (clk),
    .we    (mag_wr.we),
    .waddr (mag_wr.addr),
    .wdata (mag_wr.data),
    .raddr (rd_ptr_r),
    .rdata (mag_rdata)
  );

  smfe_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .done       (frm_done),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata),
    .mag_wr     (mag_wr)
  );

`ifndef ASSERT_OFF
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> out_bin_index == smfe_pkg::BIN_LAST)
    else $error("last bin flagged on wrong index");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> !pending_r)
    else $error("bins still pending after last bin");

  a_done_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frm_done |-> state_r == S_FRAME)
    else $error("frame done outside frame wait");

  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != smfe_pkg::ST_BIN |-> out_magnitude == '0)
    else $error("magnitude on non-bin item");

  a_no_mag_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mag_wr.we |-> state_r == S_FRAME)
    else $error("magnitude store written outside a frame");
`endif

endmodule

### hw/rtl/smfe_ram.sv
`timescale 1ns / 1ps

module smfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/smfe_sqrt.sv
`timescale 1ns / 1ps

module smfe_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] value,
  output logic        done,
  output logic [32:0] root
);

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_FIN} sq_state_t;

  sq_state_t   state_r;
  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [32:0] root_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = root_r;

  // One result bit per cycle, then round up if the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SQ_IDLE: begin
          if (go) begin
            rem_r   <= value;
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            cnt_r   <= '0;
            state_r <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= SQ_FIN;
          end
        end
        SQ_FIN: begin
          root_r  <= (rem_r > res_r) ? 33'(res_r + 64'd1) : res_r[32:0];
          done_r  <= 1'b1;
          state_r <= SQ_IDLE;
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/smfe_frame.sv
`timescale 1ns / 1ps

module smfe_frame (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smfe_pkg::frame_req_t              req,
  output logic                              done,
  output logic [smfe_pkg::ADDR_W-1:0]       ring_raddr,
  input  logic signed [smfe_pkg::SAMPLE_W-1:0] ring_rdata,
  output smfe_pkg::mag_wr_t                 mag_wr
);

  typedef enum logic [4:0] {
    F_IDLE, W_RD, W_MUL, W_WR,
    B_RDP, B_RDQ, B_LDQ, B_M0, B_M1, B_M2, B_M3, B_SUM, B_RND, B_WRP, B_WRQ,
    M_RD, M_LD, M_SQ0, M_SQ1, M_SUM, M_SQRT, F_DONE
  } fr_state_t;

  localparam int AW = smfe_pkg::ADDR_W;

  fr_state_t                          state_r;
  logic [AW-1:0]                      idx_r;
  logic [AW-1:0]                      base_r;
  logic [smfe_pkg::STAGE_W-1:0]       stage_r;
  logic [smfe_pkg::BF_W-1:0]          bf_r;
  logic signed [16:0]                 hann_r;
  logic signed [16:0]                 twr_r;
  logic signed [16:0]                 twi_r;
  logic signed [31:0]                 ur_r;
  logic signed [31:0]                 ui_r;
  logic signed [31:0]                 br_r;
  logic signed [31:0]                 bi_r;
  logic signed [63:0]                 prod_r;
  logic signed [63:0]                 acc_r;
  logic signed [63:0]                 accr_r;
  logic signed [35:0]                 vr_r;
  logic signed [35:0]                 vi_r;

  logic signed [31:0]                 mul_a;
  logic signed [31:0]                 mul_b;
  logic [AW-1:0]                      lo_mask;
  logic [AW-1:0]                      bf_ext;
  logic [AW-1:0]                      addr_p;
  logic [AW-1:0]                      addr_q;
  logic [AW-2:0]                      tw_idx;
  logic                               wk_we;
  logic [AW-1:0]                      wk_waddr;
  logic [63:0]                        wk_wdata;
  logic [AW-1:0]                      wk_raddr;
  logic [63:0]                        wk_rdata;
  logic signed [63:0]                 win_rnd;
  logic                               sq_done;
  logic [32:0]                        sq_root;
  logic [63:0]                        sq_value;

  // Cosine and sine of k/FFT_SIZE turns from the quarter-wave tables
  function automatic logic signed [31:0] cos_of(input logic [AW-1:0] k);
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    cs = signed'({1'b0, smfe_pkg::COS_TAB[k[7:0]]});
    sn = signed'({1'b0, smfe_pkg::SIN_TAB[k[7:0]]});
    unique case (k[9:8])
      2'd0: return cs;
      2'd1: return -sn;
      2'd2: return -cs;
      default: return sn;
    endcase
  endfunction

  function automatic logic signed [31:0] sin_of(input logic [AW-1:0] k);
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    cs = signed'({1'b0, smfe_pkg::COS_TAB[k[7:0]]});
    sn = signed'({1'b0, smfe_pkg::SIN_TAB[k[7:0]]});
    unique case (k[9:8])
      2'd0: return sn;
      2'd1: return cs;
      2'd2: return -sn;
      default: return -cs;
    endcase
  endfunction

  function automatic logic signed [16:0] hann_of(input logic [AW-1:0] i);
    logic signed [32:0] t;
    t = 33'sh0_4000_0000 - 33'(cos_of(i)) + 33'sd32768;
    return t[32:16];
  endfunction

  function automatic logic signed [16:0] rnd_q15(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = 33'(v) + 33'sd16384;
    return t[31:15];
  endfunction

  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = v[AW-1-b];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -37'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] rnd_tw(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd16384;
    return t[50:15];
  endfunction

  // Butterfly addressing for the current stage
  assign lo_mask = (AW'(1) << stage_r) - AW'(1);
  assign bf_ext  = AW'(bf_r);
  assign addr_p  = ((bf_ext & ~lo_mask) << 1) | (bf_ext & lo_mask);
  assign addr_q  = addr_p | (AW'(1) << stage_r);
  assign tw_idx  = (AW-1)'((bf_ext & lo_mask) << (smfe_pkg::STAGE_W'(AW - 1) - stage_r));

  assign ring_raddr = base_r + idx_r;
  assign win_rnd    = prod_r + 64'sd1024;
  assign done       = (state_r == F_DONE);
  assign sq_value   = unsigned'(acc_r + prod_r);

  // Select the shared multiplier's operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      W_MUL: begin
        mul_a = 32'(ring_rdata);
        mul_b = 32'(hann_r);
      end
      B_M0: begin
        mul_a = br_r;
        mul_b = 32'(twr_r);
      end
      B_M1: begin
        mul_a = bi_r;
        mul_b = 32'(twi_r);
      end
      B_M2: begin
        mul_a = br_r;
        mul_b = 32'(twi_r);
      end
      B_M3: begin
        mul_a = bi_r;
        mul_b = 32'(twr_r);
      end
      M_SQ0: begin
        mul_a = br_r;
        mul_b = br_r;
      end
      M_SQ1: begin
        mul_a = bi_r;
        mul_b = bi_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Work buffer ports
  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = addr_p;
    wk_wdata = '0;
    wk_raddr = addr_p;
    unique case (state_r)
      W_WR: begin
        wk_we    = 1'b1;
        wk_waddr = bit_rev(idx_r);
        wk_wdata = {win_rnd[42:11], 32'd0};
      end
      B_WRP: begin
        wk_we    = 1'b1;
        wk_waddr = addr_p;
        wk_wdata = {sat32(37'(ur_r) + 37'(vr_r)), sat32(37'(ui_r) + 37'(vi_r))};
      end
      B_WRQ: begin
        wk_we    = 1'b1;
        wk_waddr = addr_q;
        wk_wdata = {sat32(37'(ur_r) - 37'(vr_r)), sat32(37'(ui_r) - 37'(vi_r))};
      end
      B_RDQ:   wk_raddr = addr_q;
      M_RD:    wk_raddr = idx_r;
      default: wk_raddr = addr_p;
    endcase
  end

  // Store the saturated magnitude when the root comes back
  always_comb begin
    mag_wr.we   = (state_r == M_SQRT) && sq_done;
    mag_wr.addr = smfe_pkg::BIN_W'(idx_r);
    mag_wr.data = (sq_root > 33'(smfe_pkg::MAG_MAX)) ? smfe_pkg::MAG_MAX
                                                      : sq_root[smfe_pkg::MAG_W-1:0];
  end

  // Sequencer: window, butterfly stages, magnitudes
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (req.go) begin
            base_r  <= req.base;
            idx_r   <= '0;
            state_r <= W_RD;
          end
        end
        W_RD: begin
          hann_r  <= hann_of(idx_r);
          state_r <= W_MUL;
        end
        W_MUL: state_r <= W_WR;
        W_WR: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == AW'(smfe_pkg::FFT_SIZE - 1)) begin
            stage_r <= '0;
            bf_r    <= '0;
            state_r <= B_RDP;
          end else begin
            state_r <= W_RD;
          end
        end
        B_RDP: begin
          twr_r   <= rnd_q15(cos_of({1'b0, tw_idx}));
          twi_r   <= rnd_q15(-sin_of({1'b0, tw_idx}));
          state_r <= B_RDQ;
        end
        B_RDQ: begin
          ur_r    <= wk_rdata[63:32];
          ui_r    <= wk_rdata[31:0];
          state_r <= B_LDQ;
        end
        B_LDQ: begin
          br_r    <= wk_rdata[63:32];
          bi_r    <= wk_rdata[31:0];
          state_r <= B_M0;
        end
        B_M0: state_r <= B_M1;
        B_M1: begin
          acc_r   <= prod_r;
          state_r <= B_M2;
        end
        B_M2: begin
          accr_r  <= acc_r - prod_r;
          state_r <= B_M3;
        end
        B_M3: begin
          acc_r   <= prod_r;
          state_r <= B_SUM;
        end
        B_SUM: begin
          acc_r   <= acc_r + prod_r;
          state_r <= B_RND;
        end
        B_RND: begin
          vr_r    <= rnd_tw(accr_r);
          vi_r    <= rnd_tw(acc_r);
          state_r <= B_WRP;
        end
        B_WRP: state_r <= B_WRQ;
        B_WRQ: begin
          bf_r <= bf_r + smfe_pkg::BF_W'(1);
          if (bf_r == {smfe_pkg::BF_W{1'b1}}) begin
            if (stage_r == smfe_pkg::STAGE_W'(AW - 1)) begin
              idx_r   <= '0;
              state_r <= M_RD;
            end else begin
              stage_r <= stage_r + smfe_pkg::STAGE_W'(1);
              state_r <= B_RDP;
            end
          end else begin
            state_r <= B_RDP;
          end
        end
        M_RD: state_r <= M_LD;
        M_LD: begin
          br_r    <= wk_rdata[63:32];
          bi_r    <= wk_rdata[31:0];
          state_r <= M_SQ0;
        end
        M_SQ0: state_r <= M_SQ1;
        M_SQ1: begin
          acc_r   <= prod_r;
          state_r <= M_SUM;
        end
        M_SUM: state_r <= M_SQRT;
        M_SQRT: begin
          if (sq_done) begin
            idx_r <= idx_r + AW'(1);
            if (smfe_pkg::BIN_W'(idx_r) == smfe_pkg::BIN_LAST) begin
              state_r <= F_DONE;
            end else begin
              state_r <= M_RD;
            end
          end
        end
        F_DONE: state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  smfe_ram #(.WIDTH(64), .DEPTH(smfe_pkg::FFT_SIZE)) u_work (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .raddr (wk_raddr),
    .rdata (wk_rdata)
  );

  smfe_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (state_r == M_SUM),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

endmodule

### tb/tb_stft_magnitude_frame_engine_core.sv
`timescale 1ns / 1ps

module tb_stft_magnitude_frame_engine_core;

  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic                          func;
    logic [smfe_pkg::SAMPLE_W-1:0] sample;
  } cmd_item_t;

  typedef struct {
    smfe_pkg::status_t            status;
    logic [smfe_pkg::MAG_W-1:0]   magnitude;
    logic [smfe_pkg::BIN_W-1:0]   bin_index;
    logic [smfe_pkg::FRAME_W-1:0] frame_number;
    logic                         last_bin;
  } bin_result_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_func;
  logic signed [smfe_pkg::SAMPLE_W-1:0] in_sample;
  logic                                 out_valid;
  logic [2:0]                           out_status;
  logic [smfe_pkg::MAG_W-1:0]           out_magnitude;
  logic [smfe_pkg::BIN_W-1:0]           out_bin_index;
  logic [smfe_pkg::FRAME_W-1:0]         out_frame_number;
  logic                                 out_last_bin;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [smfe_pkg::HOP_W-1:0]           cfg_hop;

  cmd_item_t   pending_cmds[$];
  bin_result_t expected_results[$];
  int          idle_pct;
  bit          hold_off;
  int          errors;
  int          cycle_count;

  // Predictor state
  longint      hann_win[smfe_pkg::FFT_SIZE];
  longint      twid_re[smfe_pkg::FFT_SIZE/2];
  longint      twid_im[smfe_pkg::FFT_SIZE/2];
  longint      ring[smfe_pkg::FFT_SIZE];
  longint      buf_re[smfe_pkg::FFT_SIZE];
  longint      buf_im[smfe_pkg::FFT_SIZE];
  logic [smfe_pkg::MAG_W-1:0] mag_bins[smfe_pkg::NUM_BINS];
  int          seen_cnt, hop_cnt, rd_ptr, ring_wr;
  logic [smfe_pkg::FRAME_W-1:0] frames_done;
  bit          bins_waiting;
  int          hop_val;

  stft_magnitude_frame_engine_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_magnitude    (out_magnitude),
    .out_bin_index    (out_bin_index),
    .out_frame_number (out_frame_number),
    .out_last_bin     (out_last_bin),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_hop          (cfg_hop)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint round_shift(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Taylor cos/sin of 2*pi*k/N in Q30, first quadrant mirrored
  task automatic angle_q30(input int k, output longint c, output longint s);
    int quad, m;
    longint unsigned th, t2, term;
    longint sn, cs;
    k    = k & (smfe_pkg::FFT_SIZE - 1);
    quad = k / (smfe_pkg::FFT_SIZE / 4);
    m    = k % (smfe_pkg::FFT_SIZE / 4);
    th   = ((64'(m) * (smfe_pkg::PI_Q62 >> 21)) / 64'(smfe_pkg::FFT_SIZE) + 64'd512) >> 10;
    t2   = q30_mul(th, th);
    term = th;
    sn   = longint'(th);
    for (int n = 1; n <= 9; n++) begin
      term = q30_mul(term, t2) / 64'((2 * n) * (2 * n + 1));
      sn   = (n % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
    end
    term = 64'd1 << 30;
    cs   = longint'(term);
    for (int n = 1; n <= 9; n++) begin
      term = q30_mul(term, t2) / 64'((2 * n - 1) * (2 * n));
      cs   = (n % 2 == 1) ? cs - longint'(term) : cs + longint'(term);
    end
    case (quad)
      0: begin c = cs;  s = sn;  end
      1: begin c = -sn; s = cs;  end
      2: begin c = -cs; s = -sn; end
      default: begin c = sn; s = -cs; end
    endcase
  endtask

  task automatic build_tables();
    longint c, s;
    for (int i = 0; i < smfe_pkg::FFT_SIZE; i++) begin
      angle_q30(i, c, s);
      hann_win[i] = ((longint'(1) <<< 30) - c + 32768) >>> 16;
      if (i < smfe_pkg::FFT_SIZE / 2) begin
        twid_re[i] = round_shift(c, 15);
        twid_im[i] = round_shift(-s, 15);
      end
    end
  endtask

  function automatic longint unsigned sqrt_rounded(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (v > res) res++;
    return res;
  endfunction

  // Window, bit-reverse, radix-2 butterflies, then magnitudes
  task automatic compute_spectrum();
    int r, t, half, stp, p, q, w, kb;
    longint tmp, vr, vi, ur, ui, br, bi;
    longint unsigned e, mg;
    for (int i = 0; i < smfe_pkg::FFT_SIZE; i++) begin
      buf_re[i] = clamp32(round_shift(
                    ring[(ring_wr + i) & (smfe_pkg::FFT_SIZE - 1)] * hann_win[i], 11));
      buf_im[i] = 0;
    end
    for (int i = 0; i < smfe_pkg::FFT_SIZE; i++) begin
      r = 0;
      t = i;
      for (int k = 0; k < smfe_pkg::LOG2N; k++) begin
        r = (r << 1) | (t & 1);
        t = t >> 1;
      end
      if (i < r) begin
        tmp = buf_re[i]; buf_re[i] = buf_re[r]; buf_re[r] = tmp;
        tmp = buf_im[i]; buf_im[i] = buf_im[r]; buf_im[r] = tmp;
      end
    end
    for (int len = 2; len <= smfe_pkg::FFT_SIZE; len = len << 1) begin
      half = len / 2;
      stp  = smfe_pkg::FFT_SIZE / len;
      for (int i = 0; i < smfe_pkg::FFT_SIZE; i += len) begin
        for (int j = 0; j < half; j++) begin
          p  = i + j;
          q  = i + j + half;
          w  = (j * stp) & (smfe_pkg::FFT_SIZE / 2 - 1);
          br = buf_re[q];
          bi = buf_im[q];
          vr = round_shift(br * twid_re[w] - bi * twid_im[w], 15);
          vi = round_shift(br * twid_im[w] + bi * twid_re[w], 15);
          ur = buf_re[p];
          ui = buf_im[p];
          buf_re[p] = clamp32(ur + vr);
          buf_im[p] = clamp32(ui + vi);
          buf_re[q] = clamp32(ur - vr);
          buf_im[q] = clamp32(ui - vi);
        end
      end
    end
    for (int b = 0; b < smfe_pkg::NUM_BINS; b++) begin
      kb = b & (smfe_pkg::FFT_SIZE - 1);
      e  = longint'(buf_re[kb] * buf_re[kb]) + longint'(buf_im[kb] * buf_im[kb]);
      mg = sqrt_rounded(e);
      mag_bins[b] = (mg > 64'(smfe_pkg::MAG_MAX)) ? smfe_pkg::MAG_MAX
                                                   : mg[smfe_pkg::MAG_W-1:0];
    end
  endtask

  // Expected result of one accepted item; advances the predictor state
  task automatic predict_item(input cmd_item_t it, output bin_result_t res);
    bit fire;
    res = '{smfe_pkg::ST_STORED, '0, '0, '0, 1'b0};
    fire = 0;
    if (it.func == smfe_pkg::FUNC_PUSH) begin
      ring[ring_wr] = longint'($signed(it.sample));
      ring_wr = (ring_wr + 1) & (smfe_pkg::FFT_SIZE - 1);
      if (seen_cnt < smfe_pkg::FFT_SIZE) begin
        seen_cnt++;
        if (seen_cnt == smfe_pkg::FFT_SIZE) fire = 1;
      end else begin
        hop_cnt++;
        if (hop_cnt >= ((hop_val == 0) ? 1 : hop_val)) fire = 1;
      end
      if (fire) begin
        res.status = bins_waiting ? smfe_pkg::ST_LOST : smfe_pkg::ST_FRAME;
        hop_cnt = 0;
        compute_spectrum();
        rd_ptr = 0;
        bins_waiting = 1;
        frames_done = frames_done + 1'b1;
      end
    end else if (bins_waiting && rd_ptr < smfe_pkg::NUM_BINS) begin
      res.status       = smfe_pkg::ST_BIN;
      res.magnitude    = mag_bins[rd_ptr];
      res.bin_index    = smfe_pkg::BIN_W'(rd_ptr);
      res.frame_number = frames_done - 1'b1;
      res.last_bin     = (rd_ptr == smfe_pkg::NUM_BINS - 1);
      rd_ptr++;
      if (res.last_bin) bins_waiting = 0;
    end else begin
      res.status = smfe_pkg::ST_EMPTY;
    end
  endtask

  // Driver: hold the item while busy, otherwise launch the next one or idle
  always @(posedge clk) begin : drive_cmds
    bin_result_t res;
    cmd_item_t   it;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        it.func   = in_func;
        it.sample = in_sample;
        predict_item(it, res);
        expected_results.push_back(res);
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          it = pending_cmds.pop_front();
          start     <= 1'b1;
          in_func   <= it.func;
          in_sample <= it.sample;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [smfe_pkg::MAG_W-1:0] exp_v,
                                      logic [smfe_pkg::MAG_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : watch_results
    bin_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $realtime, out_status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", smfe_pkg::MAG_W'(exp_r.status), smfe_pkg::MAG_W'(out_status));
        check_field("magnitude", exp_r.magnitude, out_magnitude);
        check_field("bin_index", smfe_pkg::MAG_W'(exp_r.bin_index),
                    smfe_pkg::MAG_W'(out_bin_index));
        check_field("frame_number", smfe_pkg::MAG_W'(exp_r.frame_number),
                    smfe_pkg::MAG_W'(out_frame_number));
        check_field("last_bin", smfe_pkg::MAG_W'(exp_r.last_bin),
                    smfe_pkg::MAG_W'(out_last_bin));
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stft_magnitude_frame_engine_core NOT OK");
      $finish;
    end
  end

  task automatic push_sample(input logic [smfe_pkg::SAMPLE_W-1:0] v);
    pending_cmds.push_back('{smfe_pkg::FUNC_PUSH, v});
  endtask

  task automatic read_bin();
    pending_cmds.push_back('{smfe_pkg::FUNC_READ, smfe_pkg::SAMPLE_W'($urandom)});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_hop(input int v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_hop   <= smfe_pkg::HOP_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hop_val = v & 11'h7FF;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [smfe_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return smfe_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int phase_idle[4];
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_func   = smfe_pkg::FUNC_PUSH;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_hop   = '0;
    idle_pct  = 0;
    hold_off  = 0;
    errors    = 0;
    cycle_count = 0;
    build_tables();
    for (int i = 0; i < smfe_pkg::FFT_SIZE; i++) ring[i] = 0;
    seen_cnt = 0; hop_cnt = 0; rd_ptr = 0; ring_wr = 0;
    frames_done = '0; bins_waiting = 0; hop_val = smfe_pkg::HOP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reads with nothing pending, extreme samples, saturating first frame
    read_bin();
    read_bin();
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    for (int i = 0; i < smfe_pkg::FFT_SIZE - 4; i++) push_sample(16'h8000);
    wait_idle();
    idle_pct = 69;
    for (int i = 0; i < smfe_pkg::NUM_BINS + 1; i++) read_bin();

    // Smallest hop: a frame per push, second one drops unread bins
    write_hop(1);
    idle_pct = 0;
    push_sample(rand_sample());
    push_sample(rand_sample());
    repeat (3) read_bin();

    // Hop of zero acts as one
    write_hop(0);
    push_sample(rand_sample());
    idle_pct = 32;
    for (int i = 0; i < 20; i++) read_bin();

    // Largest hop, then lower it below the count so the next push fires
    write_hop(2047);
    for (int i = 0; i < 30; i++) push_sample(rand_sample());
    read_bin();
    read_bin();
    write_hop(5);
    push_sample(rand_sample());
    for (int i = 0; i < 10; i++) read_bin();

    // Random traffic across idle phases
    write_hop(20);
    phase_idle = '{0, 69, 32, 69};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(99) < 55) push_sample(rand_sample());
        else read_bin();
        if (ph == 2 && i == 15) begin
          // Pause the sender until every result is back
          hold_off = 1;
          while (pending_cmds.size() > 0 && expected_results.size() > 0) @(negedge clk);
          @(negedge clk);
          while (start || busy || expected_results.size() > 0) @(negedge clk);
          hold_off = 0;
        end
      end
      while (pending_cmds.size() > 0) @(negedge clk);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_stft_magnitude_frame_engine_core OK");
    end else begin
      $display("tb_stft_magnitude_frame_engine_core NOT OK");
    end
    $finish;
  end

endmodule
